// File: hdl/lnlms_pkg.sv
// shared constants, types and register codes for the leaky nlms filter
`timescale 1ns / 1ps
package lnlms_pkg;

  localparam int LINE_DEPTH = 512;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int MAX_TAPS   = 128;
  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int TAP_CW     = TAP_AW + 1;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_AW     = 3;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_DELAY = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TAPS  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_STEP  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LEAK  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MODE  = 3'd4;

  localparam logic [8:0]  DELAY_RST = 9'd16;
  localparam logic [7:0]  TAPS_RST  = 8'd64;
  localparam logic [15:0] STEP_RST  = 16'd655;
  localparam logic [15:0] LEAK_RST  = 16'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P1_RD,
    ST_P1_MUL,
    ST_P1_ACC,
    ST_EST,
    ST_P2_RD,
    ST_P2_MUL,
    ST_P2_SCALE,
    ST_P2_START,
    ST_P2_DIV,
    ST_P2_UPD,
    ST_FIN
  } lnlms_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hdl/lnlms_if.sv
// stream interfaces for input samples and filter results
`timescale 1ns / 1ps
interface lnlms_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface lnlms_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// File: hdl/leaky_nlms_adaptive_filter.sv
// Leaky normalized LMS line enhancer, one real sample in, one sample out.
// Channels: samples (sink) takes sample_in, results (source) gives
// sample_out; both transfer when valid and ready are high at a clock edge.
// Configuration: cfg_we/cfg_index/cfg_data write delay, tap count, step,
// leak and mode; write only while the block is idle.
// After reset a clearing pass zeroes the history line and the
// weights; samples.ready stays low during it.
// Per sample with T taps in use: a first pass reads, multiplies and
// accumulates each tap to form the estimate and energy, and a second
// pass reads, multiplies, scales and divides each tap through the
// bit-serial divider to update the weights. With T = 0 both passes
// are skipped and the result goes straight from the estimate step.
// The result sits in an output register; a new sample is taken while it
// waits. If results.ready stays low, the next result holds in its final
// state until the register frees up, and no further sample is taken.
// The history line and weights sit in single-port-write rams with a
// registered read.
`timescale 1ns / 1ps
module leaky_nlms_adaptive_filter (
  input  logic                          clk,
  input  logic                          rst,
  lnlms_in_if.sink                      samples,
  lnlms_out_if.source                   results,
  input  logic                          cfg_we,
  input  logic [lnlms_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [lnlms_pkg::CFG_W-1:0]   cfg_data
);
  import lnlms_pkg::*;

  lnlms_state_t state, state_next;

  logic [8:0]  delay_taps;
  logic [7:0]  tap_count;
  logic [15:0] step_size;
  logic [15:0] leak_factor;
  logic        mode;

  logic [LINE_AW-1:0] wp;
  logic [LINE_AW-1:0] base;
  logic [LINE_AW-1:0] clr_addr;
  logic [TAP_CW-1:0]  j;
  logic [TAP_CW-1:0]  taps;
  logic [TAP_CW-1:0]  taps_eff;

  logic signed [SAMPLE_W-1:0] x0;
  logic signed [47:0]         acc;
  logic [47:0]                energy;
  logic signed [47:0]         prod;
  logic [31:0]                xsq;
  logic signed [17:0]         est;
  logic signed [18:0]         err;
  logic [48:0]                dvs;
  logic [32:0]                scl;
  logic [31:0]                leak_mag;
  logic                       w_neg;
  logic [33:0]                ex;
  logic                       d_neg;
  logic [49:0]                a;

  logic               h_we, w_we;
  logic [LINE_AW-1:0] h_waddr, h_raddr;
  logic [TAP_AW-1:0]  w_waddr;
  logic [15:0]        h_wdata, h_rdata;
  logic [31:0]        w_wdata, w_rdata;

  logic [63:0] quo;
  div_status_t div_st;
  logic        div_start;

  logic signed [15:0] x;
  logic signed [31:0] w;
  logic               take_in;
  logic               load_out;

  // combinational datapath terms
  logic signed [48:0] acc_sum;
  logic [48:0]        en_sum;
  logic signed [18:0] err_new;
  logic [15:0]        x_mag;
  logic [17:0]        err_mag;
  logic [18:0]        err_neg_v;
  logic [31:0]        w_mag;
  logic [63:0]        leak_prod;
  logic [54:0]        q_cap;
  logic signed [56:0] leaked_s;
  logic signed [56:0] delta_s;
  logic signed [56:0] nw_sum;
  logic [31:0]        nw;
  logic signed [18:0] res;
  logic [15:0]        res_sat;

  assign x = h_rdata;
  assign w = w_rdata;

  assign taps_eff = (tap_count > 8'(MAX_TAPS)) ? TAP_CW'(MAX_TAPS) : TAP_CW'(tap_count);

  lnlms_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  lnlms_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_wts (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(j[TAP_AW-1:0]), .rdata(w_rdata)
  );

  lnlms_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({a, 14'd0}), .divisor(dvs),
    .quotient(quo), .status(div_st)
  );

  assign samples.ready = (state == ST_IDLE);
  assign take_in       = samples.valid && samples.ready;
  assign load_out      = (state == ST_FIN) && (!results.valid || results.ready);
  assign div_start     = (state == ST_P2_START);

  assign h_raddr = base + LINE_AW'(j);

  always_comb begin
    h_we    = 1'b0;
    h_waddr = wp;
    h_wdata = samples.sample_in;
    if (state == ST_CLEAR) begin
      h_we    = 1'b1;
      h_waddr = clr_addr;
      h_wdata = '0;
    end else if (take_in) begin
      h_we = 1'b1;
    end
  end

  // arithmetic
  always_comb begin
    acc_sum   = {acc[47], acc} + {prod[47], prod};
    en_sum    = {1'b0, energy} + 49'(xsq);
    err_new   = 19'(x0) - 19'($signed(acc[47:30]));
    x_mag     = x[15] ? 16'(-x) : 16'(x);
    err_neg_v = -err;
    err_mag   = err[18] ? err_neg_v[17:0] : err[17:0];
    w_mag     = w[31] ? 32'(-w) : 32'(w);
    leak_prod = 64'(w_mag) * 64'(scl);
    q_cap     = (quo[63:54] != '0) ? {1'b1, 54'd0} : quo[54:0];
    leaked_s  = w_neg ? -57'(leak_mag) : 57'(leak_mag);
    delta_s   = d_neg ? -57'(q_cap) : 57'(q_cap);
    nw_sum    = leaked_s + delta_s;
    if (nw_sum > 57'sd2147483647) begin
      nw = 32'h7fff_ffff;
    end else if (nw_sum < -57'sd2147483648) begin
      nw = 32'h8000_0000;
    end else begin
      nw = nw_sum[31:0];
    end
    res = mode ? 19'(est) : err;
    if (res > 19'sd32767) begin
      res_sat = 16'h7fff;
    end else if (res < -19'sd32768) begin
      res_sat = 16'h8000;
    end else begin
      res_sat = res[15:0];
    end
  end

  always_comb begin
    w_we    = 1'b0;
    w_waddr = j[TAP_AW-1:0];
    w_wdata = nw;
    if (state == ST_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = clr_addr[TAP_AW-1:0];
      w_wdata = '0;
    end else if (state == ST_P2_UPD) begin
      w_we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_addr == LINE_AW'(LINE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (take_in) begin
          state_next = (taps_eff == '0) ? ST_EST : ST_P1_RD;
        end
      end
      ST_P1_RD:    state_next = ST_P1_MUL;
      ST_P1_MUL:   state_next = ST_P1_ACC;
      ST_P1_ACC:   state_next = (j + 1'b1 == taps) ? ST_EST : ST_P1_RD;
      ST_EST:      state_next = (taps == '0) ? ST_FIN : ST_P2_RD;
      ST_P2_RD:    state_next = ST_P2_MUL;
      ST_P2_MUL:   state_next = ST_P2_SCALE;
      ST_P2_SCALE: state_next = ST_P2_START;
      ST_P2_START: state_next = ST_P2_DIV;
      ST_P2_DIV:   if (div_st.done) state_next = ST_P2_UPD;
      ST_P2_UPD:   state_next = (j + 1'b1 == taps) ? ST_FIN : ST_P2_RD;
      ST_FIN:      if (load_out) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // configuration registers and control
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_taps  <= DELAY_RST;
      tap_count   <= TAPS_RST;
      step_size   <= STEP_RST;
      leak_factor <= LEAK_RST;
      mode        <= 1'b0;
      wp          <= '0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DELAY: delay_taps  <= cfg_data[8:0];
          REG_TAPS:  tap_count   <= cfg_data[7:0];
          REG_STEP:  step_size   <= cfg_data;
          REG_LEAK:  leak_factor <= cfg_data;
          REG_MODE:  mode        <= cfg_data[0];
          default: ;
        endcase
      end
      if (load_out) begin
        results.valid <= 1'b1;
        wp            <= wp - 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      results.sample_out <= res_sat;
    end
    unique case (state)
      ST_IDLE: begin
        x0     <= samples.sample_in;
        base   <= wp + delay_taps;
        taps   <= taps_eff;
        j      <= '0;
        acc    <= '0;
        energy <= '0;
      end
      ST_P1_MUL: begin
        prod <= 48'(w) * 48'(x);
        xsq  <= 32'(32'(x) * 32'(x));
      end
      ST_P1_ACC: begin
        if (acc_sum[48] != acc_sum[47]) begin
          acc <= acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
          acc <= acc_sum[47:0];
        end
        energy <= en_sum[48] ? {48{1'b1}} : en_sum[47:0];
        j      <= j + 1'b1;
      end
      ST_EST: begin
        est <= acc[47:30];
        err <= err_new;
        dvs <= {1'b0, energy} + 49'd1;
        scl <= 33'h1_0000_0000 - 33'(32'(step_size) * 32'(leak_factor));
        j   <= '0;
      end
      ST_P2_MUL: begin
        leak_mag <= leak_prod[63:32];
        w_neg    <= w[31];
        ex       <= 34'(err_mag) * 34'(x_mag);
        d_neg    <= err[18] ^ x[15];
      end
      ST_P2_SCALE: begin
        a <= 50'(ex) * 50'(step_size);
      end
      ST_P2_UPD: begin
        j <= j + 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == ST_P2_DIV)
    else $error("divider finished outside the wait state");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && results.valid && !results.ready |=> state == ST_FIN)
    else $error("result dropped while output register was full");

  a_weight_write: assert property (@(posedge clk) disable iff (rst)
    w_we |-> state == ST_P2_UPD || state == ST_CLEAR)
    else $error("weight write outside update");

  a_tap_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_P1_ACC || state == ST_P2_UPD |-> j < taps)
    else $error("tap index beyond taps in use");
`endif
endmodule

// File: hdl/lnlms_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module lnlms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/lnlms_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lnlms_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [63:0]              dividend,
  input  logic [48:0]              divisor,
  output logic [63:0]              quotient,
  output lnlms_pkg::div_status_t   status
);
  import lnlms_pkg::*;

  logic [48:0] rem;
  logic [63:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [49:0] trial;
  logic [49:0] diff;
  logic        ge;

  assign trial = {rem, quo[63]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[48:0] : trial[48:0];
      quo <= {quo[62:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;
endmodule

// File: tb/testbench.sv
// self-checking testbench for the leaky nlms line enhancer: table, random phases, predictor
`timescale 1ns / 1ps
module testbench;
  import lnlms_pkg::*;

  localparam int HOLD_CYCLES = 2000;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lnlms_in_if samples_if ();
  lnlms_out_if results_if ();

  initial begin
    samples_if.valid = 1'b0;
    samples_if.sample_in = '0;
    results_if.ready = 1'b0;
  end

  leaky_nlms_adaptive_filter i_dut (
    .clk(clk), .rst(rst), .samples(samples_if), .results(results_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow filter state
  logic signed [SAMPLE_W-1:0] hist [LINE_DEPTH];
  logic signed [WEIGHT_W-1:0] wts [MAX_TAPS];
  logic [LINE_AW-1:0] wptr;
  logic [8:0]  sh_delay;
  logic [7:0]  sh_taps;
  logic [15:0] sh_step;
  logic [15:0] sh_leak;
  logic        sh_mode;

  logic [SAMPLE_W-1:0] out_q [$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int cycles = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_cnt = 0;
  int free_cnt = 0;

  function automatic logic [SAMPLE_W-1:0] nlms_predict(logic signed [SAMPLE_W-1:0] s);
    longint acc, est, err, x, w, leaked, delta, nw, res;
    longint unsigned energy, dvs, scl, wm, a, q;
    int taps, base, idx;
    acc = 0;
    energy = 0;
    taps = (sh_taps > MAX_TAPS) ? MAX_TAPS : int'(sh_taps);
    hist[wptr] = s;
    base = (int'(wptr) + int'(sh_delay)) % LINE_DEPTH;
    for (int j = 0; j < taps; j++) begin
      idx = (base + j) % LINE_DEPTH;
      x = longint'(hist[idx]);
      acc = acc + longint'(wts[j]) * x;
      if (acc > (64'sd1 <<< 47) - 1) acc = (64'sd1 <<< 47) - 1;
      if (acc < -(64'sd1 <<< 47)) acc = -(64'sd1 <<< 47);
      energy = energy + longint'(x * x);
      if (energy > (64'd1 << 48) - 1) energy = (64'd1 << 48) - 1;
    end
    est = acc >>> 30;
    err = longint'(s) - est;
    dvs = energy + 1;
    scl = (64'd1 << 32) - longint'(sh_step) * longint'(sh_leak);
    for (int j = 0; j < taps; j++) begin
      idx = (base + j) % LINE_DEPTH;
      x = longint'(hist[idx]);
      w = longint'(wts[j]);
      wm = (w < 0) ? -w : w;
      leaked = longint'((wm * scl) >> 32);
      if (w < 0) leaked = -leaked;
      a = ((err < 0) ? -err : err) * ((x < 0) ? -x : x) * longint'(sh_step);
      q = a / dvs;
      // quotient cap before the 14 fraction bits
      if (q >= (64'd1 << 40)) q = 64'd1 << 54;
      else q = (a << 14) / dvs;
      delta = longint'(q);
      if ((err < 0) != (x < 0)) delta = -delta;
      nw = leaked + delta;
      if (nw > 64'sd2147483647) nw = 64'sd2147483647;
      if (nw < -64'sd2147483648) nw = -64'sd2147483648;
      wts[j] = nw[31:0];
    end
    wptr = wptr - 1'b1;
    res = sh_mode ? est : err;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  // receiver: random stalls, quiet stretches, one long hold on request
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      results_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      results_if.ready <= 1'b0;
    end else if (free_cnt > 0) begin
      free_cnt <= free_cnt - 1;
      results_if.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) free_cnt <= $urandom_range(100, 800);
      results_if.ready <= ($urandom_range(0, 99) < 65);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      n_out++;
      if (out_q.size() == 0) begin
        $error("unexpected sample_out transfer: actual %0d", $signed(results_if.sample_out));
        errors++;
      end else begin
        if (results_if.sample_out !== out_q[0]) begin
          $error("sample_out mismatch: expected %0d actual %0d",
                 $signed(out_q[0]), $signed(results_if.sample_out));
          errors++;
        end
        void'(out_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic put_sample(logic signed [15:0] s, logic typed, logic [15:0] want);
    logic [15:0] pred;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    samples_if.valid <= 1'b1;
    samples_if.sample_in <= s;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    pred = nlms_predict(s);
    out_q.push_back(typed ? want : pred);
    n_in++;
    burst_left--;
  endtask

  task automatic drain;
    samples_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (out_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DELAY: sh_delay = data[8:0];
      REG_TAPS:  sh_taps  = data[7:0];
      REG_STEP:  sh_step  = data;
      REG_LEAK:  sh_leak  = data;
      REG_MODE:  sh_mode  = data[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [8:0] d, logic [7:0] t, logic [15:0] st, logic [15:0] lk,
                         logic m);
    reg_write(REG_DELAY, CFG_W'(d));
    reg_write(REG_TAPS, CFG_W'(t));
    reg_write(REG_STEP, st);
    reg_write(REG_LEAK, lk);
    reg_write(REG_MODE, CFG_W'(m));
  endtask

  function automatic logic signed [15:0] rand_sample(logic signed [15:0] prev);
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2:    return prev + 16'($signed($urandom_range(0, 2047)) - 1024);
      3:       return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  typedef struct {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [15:0] data;
    logic [15:0] smp;
    logic        typed;
    logic [15:0] want;
  } row_t;

  row_t plan [$];
  int n_phases = 0;

  initial begin
    logic signed [15:0] s;
    int items, t;
    for (int i = 0; i < LINE_DEPTH; i++) hist[i] = '0;
    for (int i = 0; i < MAX_TAPS; i++) wts[i] = '0;
    wptr = '0;
    sh_delay = DELAY_RST;
    sh_taps = TAPS_RST;
    sh_step = STEP_RST;
    sh_leak = LEAK_RST;
    sh_mode = 1'b0;

    // until the newest samples reach the taps the error equals the sample
    plan.push_back('{0, 0, 0, 16'h7fff, 1, 16'h7fff});
    plan.push_back('{0, 0, 0, 16'h8000, 1, 16'h8000});
    plan.push_back('{0, 0, 0, 16'h0000, 1, 16'h0000});
    plan.push_back('{0, 0, 0, 16'hffff, 1, 16'hffff});
    plan.push_back('{0, 0, 0, 16'h0001, 1, 16'h0001});
    plan.push_back('{0, 0, 0, 16'h4000, 1, 16'h4000});
    plan.push_back('{0, 0, 0, 16'hc000, 1, 16'hc000});
    plan.push_back('{0, 0, 0, 16'h5555, 1, 16'h5555});
    plan.push_back('{0, 0, 0, 16'haaaa, 1, 16'haaaa});
    plan.push_back('{0, 0, 0, 16'h0064, 1, 16'h0064});
    plan.push_back('{0, 0, 0, 16'hff9c, 1, 16'hff9c});
    plan.push_back('{0, 0, 0, 16'h7fff, 1, 16'h7fff});
    plan.push_back('{0, 0, 0, 16'h7fff, 1, 16'h7fff});
    plan.push_back('{0, 0, 0, 16'h8000, 1, 16'h8000});
    plan.push_back('{0, 0, 0, 16'h8000, 1, 16'h8000});
    plan.push_back('{0, 0, 0, 16'h0007, 1, 16'h0007});
    plan.push_back('{1, REG_TAPS, 16'd4, 0, 0, 0});
    // out-of-range indexes must be ignored
    plan.push_back('{1, 3'd5, 16'h0000, 0, 0, 0});
    plan.push_back('{1, 3'd7, 16'hffff, 0, 0, 0});
    plan.push_back('{0, 0, 0, 16'h2ee0, 0, 0});
    plan.push_back('{0, 0, 0, 16'he0c0, 0, 0});
    plan.push_back('{0, 0, 0, 16'h0bb8, 0, 0});
    plan.push_back('{1, REG_MODE, 16'd1, 0, 0, 0});
    plan.push_back('{0, 0, 0, 16'h1234, 0, 0});
    plan.push_back('{1, REG_TAPS, 16'd0, 0, 0, 0});
    // no taps: estimate zero, error is the sample
    plan.push_back('{0, 0, 0, 16'h7fff, 1, 16'h0000});
    plan.push_back('{1, REG_MODE, 16'd0, 0, 0, 0});
    plan.push_back('{0, 0, 0, 16'h8000, 1, 16'h8000});
    plan.push_back('{1, REG_TAPS, 16'd200, 0, 0, 0});
    plan.push_back('{1, REG_STEP, 16'hffff, 0, 0, 0});
    plan.push_back('{0, 0, 0, 16'h6000, 0, 0});
    plan.push_back('{1, REG_TAPS, 16'd3, 0, 0, 0});
    plan.push_back('{1, REG_DELAY, 16'd511, 0, 0, 0});
    plan.push_back('{1, REG_LEAK, 16'hffff, 0, 0, 0});
    plan.push_back('{0, 0, 0, 16'h9abc, 0, 0});
    plan.push_back('{0, 0, 0, 16'h3210, 0, 0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        reg_write(plan[i].idx, plan[i].data);
      end else begin
        put_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end
    end

    s = 0;
    for (int ph = 0; ph < 14; ph++) begin
      drain();
      n_phases++;
      items = 130;
      case (ph)
        0: set_all(9'd0, 8'd1, 16'hffff, 16'hffff, 1'b0);
        1: set_all(9'd511, 8'd2, 16'h0000, 16'h0000, 1'b1);
        2: begin set_all(9'd5, 8'd128, 16'd655, 16'd1, 1'b0); items = 12; end
        3: begin set_all(9'd300, 8'd255, 16'd30000, 16'd3, 1'b1); items = 6; end
        4: begin set_all(9'd1, 8'd0, 16'd1000, 16'd10, 1'b0); items = 40; end
        default: begin
          t = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          set_all(9'($urandom_range(0, 511)), 8'(t), 16'($urandom()),
                  16'($urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom()),
                  1'($urandom_range(0, 1)));
        end
      endcase
      // long receiver hold while samples keep coming
      if (ph == 6) hold_req <= 1'b1;
      for (int k = 0; k < items; k++) begin
        s = rand_sample(s);
        put_sample(s, 1'b0, '0);
      end
    end

    drain();
    if (out_q.size() != 0) begin
      $error("%0d expected sample_out values never arrived", out_q.size());
      errors++;
    end
    $display("run: %0d samples in, %0d results out, %0d register phases, %0d cycles",
             n_in, n_out, n_phases, cycles);
    $display("covered tap counts 0..255, delay and step extremes, both modes, long stall");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
